FILE: rtl/core/ddw_pkg.sv
// Shared constants and calendar helper functions for the date difference block.
package ddw_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned CNT_W   = 22;
    localparam int unsigned WEEK_W  = 19;
    localparam int unsigned WD_W    = 3;
    localparam int unsigned PB_W    = 12;   // (y-1)/4 + days before month + day + 1
    localparam int unsigned WS_W    = 5;    // weekday partial sums, at most 30

    localparam logic [YEAR_W-1:0] YEAR_MIN    = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd9999;
    localparam logic [YEAR_W-1:0] WD_YEAR_LO  = 14'd1800;
    localparam logic [YEAR_W-1:0] WD_YEAR_MID = 14'd1900;
    localparam logic [YEAR_W-1:0] WD_YEAR_HI  = 14'd2000;
    localparam logic [YEAR_W-1:0] WD_YEAR_END = 14'd2099;
    localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(n/7) = (n * RECIP7) >> RECIP7_SHIFT, exact for n < 2^22
    localparam int unsigned       RECIP7_SHIFT = 25;
    localparam int unsigned       PROD_W       = 45;
    localparam logic [22:0]       RECIP7       = 23'd4793491;

    // Century codes and leap correction (minus one, modulo seven)
    localparam logic [WD_W-1:0] CENT_1800 = 3'd2;
    localparam logic [WD_W-1:0] CENT_1900 = 3'd0;
    localparam logic [WD_W-1:0] CENT_2000 = 3'd6;
    localparam logic [WD_W-1:0] LEAP_FIX  = 3'd6;

    // Residue mod 7 of a 7-bit value: 8 is 1 mod 7, so fold octal digits.
    function automatic logic [WD_W-1:0] mod7(input logic [6:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(v[6:3]) + 5'(v[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[WD_W-1:0];
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic [WD_W-1:0] month_code(input logic [MONTH_W-1:0] m);
        logic [WD_W-1:0] c;
        case (m)
            4'd2, 4'd3, 4'd11: c = 3'd3;
            4'd4:              c = 3'd6;
            4'd5:              c = 3'd1;
            4'd6:              c = 3'd4;
            4'd7:              c = 3'd6;
            4'd8:              c = 3'd2;
            4'd9, 4'd12:       c = 3'd5;
            default:           c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/ddw_if.sv
// Handshake interfaces for the date input channel and the result channel.
interface ddw_in_if;
    logic                          valid;
    logic                          ready;
    logic [ddw_pkg::DAY_W-1:0]     first_day;
    logic [ddw_pkg::MONTH_W-1:0]   first_month;
    logic [ddw_pkg::YEAR_W-1:0]    first_year;
    logic [ddw_pkg::DAY_W-1:0]     second_day;
    logic [ddw_pkg::MONTH_W-1:0]   second_month;
    logic [ddw_pkg::YEAR_W-1:0]    second_year;

    modport source (output valid, first_day, first_month, first_year,
                    second_day, second_month, second_year, input ready);
    modport sink   (input valid, first_day, first_month, first_year,
                    second_day, second_month, second_year, output ready);
endinterface

interface ddw_out_if;
    logic                          valid;
    logic                          ready;
    logic                          first_valid;
    logic                          second_valid;
    logic                          order_error;
    logic [ddw_pkg::CNT_W-1:0]     day_count;
    logic [ddw_pkg::WEEK_W-1:0]    whole_weeks;
    logic [ddw_pkg::WD_W-1:0]      extra_days;
    logic [ddw_pkg::WD_W-1:0]      first_weekday;
    logic [ddw_pkg::WD_W-1:0]      second_weekday;
    logic [1:0]                    weekday_known;

    modport source (output valid, first_valid, second_valid, order_error, day_count,
                    whole_weeks, extra_days, first_weekday, second_weekday,
                    weekday_known, input ready);
    modport sink   (input valid, first_valid, second_valid, order_error, day_count,
                    whole_weeks, extra_days, first_weekday, second_weekday,
                    weekday_known, output ready);
endinterface

FILE: rtl/core/date_difference_and_weekday_top.sv
// Top level: five-stage pipeline for date validity, day difference and weekdays.
//
//  channel  | dir | payload                                     | handshake
//  ---------+-----+---------------------------------------------+-------------
//  i_in     | in  | two dates (day, month, year)                | valid/ready
//  o_out    | out | valid flags, order flag, count, weekdays    | valid/ready
//
// One transfer per cycle is sustained while o_out is ready. Stages, in order:
// field decode and products, ordinals, difference and weekday residue,
// reciprocal multiply by 1/7, remainder.
// Reset clears the stage valid bits only. A stage holds its contents while
// the stage after it is full and not moving, so a stall loses nothing.
module date_difference_and_weekday_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ddw_in_if.sink    i_in,
    ddw_out_if.source o_out
);

    localparam int unsigned NDATE = 2;

    // stage valid bits and advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5 = !r_v5 || o_out.ready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_in.ready = w_en1;

    // ---------------- stage 1: decode each date ----------------
    logic [ddw_pkg::DAY_W-1:0]   w_d [NDATE];
    logic [ddw_pkg::MONTH_W-1:0] w_m [NDATE];
    logic [ddw_pkg::YEAR_W-1:0]  w_y [NDATE];

    assign w_d[0] = i_in.first_day;
    assign w_m[0] = i_in.first_month;
    assign w_y[0] = i_in.first_year;
    assign w_d[1] = i_in.second_day;
    assign w_m[1] = i_in.second_month;
    assign w_y[1] = i_in.second_year;

    logic                           n_ok1  [NDATE];
    logic                           n_kn1  [NDATE];
    logic [ddw_pkg::CNT_W-1:0]      n_pa1  [NDATE];
    logic [ddw_pkg::PB_W-1:0]       n_pb1  [NDATE];
    logic [6:0]                     n_yq1  [NDATE];
    logic [ddw_pkg::WS_W-1:0]       n_ws1  [NDATE];

    logic                           r_ok1  [NDATE];
    logic                           r_kn1  [NDATE];
    logic [ddw_pkg::CNT_W-1:0]      r_pa1  [NDATE];
    logic [ddw_pkg::PB_W-1:0]       r_pb1  [NDATE];
    logic [6:0]                     r_yq1  [NDATE];
    logic [ddw_pkg::WS_W-1:0]       r_ws1  [NDATE];

    always_comb begin
        logic                         leap;
        logic [ddw_pkg::YEAR_W-1:0]   ym1;
        logic [ddw_pkg::YEAR_W-1:0]   yy_full;
        logic [6:0]                   yy;
        logic [ddw_pkg::WD_W-1:0]     cent;
        logic                         in_range;
        for (int i = 0; i < NDATE; i++) begin
            leap = (w_y[i][1:0] == 2'b00);
            n_ok1[i] = (w_m[i] >= ddw_pkg::MONTH_JAN) && (w_m[i] <= ddw_pkg::MONTH_DEC)
                    && (w_y[i] >= ddw_pkg::YEAR_MIN) && (w_y[i] <= ddw_pkg::YEAR_MAX)
                    && (w_d[i] != '0) && (w_d[i] <= ddw_pkg::month_len(w_m[i], leap));
            ym1 = w_y[i] - 14'd1;
            n_pa1[i] = 22'({8'd0, ym1} * {13'd0, ddw_pkg::DAYS_PER_YEAR});
            n_pb1[i] = ddw_pkg::PB_W'(ym1 >> 2)
                     + ddw_pkg::PB_W'(ddw_pkg::days_before(w_m[i]))
                     + ddw_pkg::PB_W'(w_d[i])
                     + ddw_pkg::PB_W'((w_m[i] > ddw_pkg::MONTH_FEB) && leap);

            // century code and year within century
            in_range = 1'b1;
            if (w_y[i] >= ddw_pkg::WD_YEAR_LO && w_y[i] < ddw_pkg::WD_YEAR_MID) begin
                cent    = ddw_pkg::CENT_1800;
                yy_full = w_y[i] - ddw_pkg::WD_YEAR_LO;
            end else if (w_y[i] >= ddw_pkg::WD_YEAR_MID && w_y[i] < ddw_pkg::WD_YEAR_HI) begin
                cent    = ddw_pkg::CENT_1900;
                yy_full = w_y[i] - ddw_pkg::WD_YEAR_MID;
            end else if (w_y[i] >= ddw_pkg::WD_YEAR_HI && w_y[i] <= ddw_pkg::WD_YEAR_END) begin
                cent    = ddw_pkg::CENT_2000;
                yy_full = w_y[i] - ddw_pkg::WD_YEAR_HI;
            end else begin
                cent     = '0;
                yy_full  = '0;
                in_range = 1'b0;
            end
            yy = yy_full[6:0];
            n_kn1[i] = n_ok1[i] && in_range;
            n_yq1[i] = yy + (yy >> 2);
            n_ws1[i] = ddw_pkg::WS_W'(cent)
                     + ddw_pkg::WS_W'(ddw_pkg::mod7(7'(w_d[i])))
                     + ddw_pkg::WS_W'(ddw_pkg::month_code(w_m[i]))
                     + (((w_m[i] <= ddw_pkg::MONTH_FEB) && leap)
                        ? ddw_pkg::WS_W'(ddw_pkg::LEAP_FIX) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= i_in.valid;
        end
        if (w_en1) begin
            r_ok1 <= n_ok1;
            r_kn1 <= n_kn1;
            r_pa1 <= n_pa1;
            r_pb1 <= n_pb1;
            r_yq1 <= n_yq1;
            r_ws1 <= n_ws1;
        end
    end

    // ---------------- stage 2: ordinals ----------------
    logic                      r_ok2  [NDATE];
    logic                      r_kn2  [NDATE];
    logic [ddw_pkg::CNT_W-1:0] r_ord2 [NDATE];
    logic [ddw_pkg::WS_W-1:0]  r_ws2  [NDATE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
        if (w_en2) begin
            for (int i = 0; i < NDATE; i++) begin
                r_ok2[i]  <= r_ok1[i];
                r_kn2[i]  <= r_kn1[i];
                r_ord2[i] <= r_pa1[i] + ddw_pkg::CNT_W'(r_pb1[i]);
                r_ws2[i]  <= r_ws1[i] + ddw_pkg::WS_W'(ddw_pkg::mod7(r_yq1[i]));
            end
        end
    end

    // ---------------- stage 3: difference, order check, weekdays ----------------
    logic                      w_both2;
    logic                      w_lt2;
    logic                      r_ok3 [NDATE];
    logic [1:0]                r_kn3;
    logic [ddw_pkg::WD_W-1:0]  r_wd3 [NDATE];
    logic                      r_ord_err3;
    logic [ddw_pkg::CNT_W-1:0] r_cnt3;

    assign w_both2 = r_ok2[0] && r_ok2[1];
    assign w_lt2   = r_ord2[1] < r_ord2[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en3) begin
            r_v3 <= r_v2;
        end
        if (w_en3) begin
            for (int i = 0; i < NDATE; i++) begin
                r_ok3[i] <= r_ok2[i];
                r_kn3[i] <= r_kn2[i];
                r_wd3[i] <= r_kn2[i] ? ddw_pkg::mod7(7'(r_ws2[i])) : '0;
            end
            r_ord_err3 <= w_both2 && w_lt2;
            r_cnt3     <= (w_both2 && !w_lt2) ? (r_ord2[1] - r_ord2[0]) : '0;
        end
    end

    // ---------------- stage 4: quotient by reciprocal multiply ----------------
    logic [ddw_pkg::PROD_W-1:0] w_prod3;
    logic                       r_ok4 [NDATE];
    logic [1:0]                 r_kn4;
    logic [ddw_pkg::WD_W-1:0]   r_wd4 [NDATE];
    logic                       r_ord_err4;
    logic [ddw_pkg::CNT_W-1:0]  r_cnt4;
    logic [ddw_pkg::WEEK_W-1:0] r_q4;

    assign w_prod3 = ddw_pkg::PROD_W'(r_cnt3) * ddw_pkg::PROD_W'(ddw_pkg::RECIP7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en4) begin
            r_v4 <= r_v3;
        end
        if (w_en4) begin
            r_ok4      <= r_ok3;
            r_kn4      <= r_kn3;
            r_wd4      <= r_wd3;
            r_ord_err4 <= r_ord_err3;
            r_cnt4     <= r_cnt3;
            r_q4       <= w_prod3[ddw_pkg::RECIP7_SHIFT +: ddw_pkg::WEEK_W];
        end
    end

    // ---------------- stage 5: remainder, output register ----------------
    logic [ddw_pkg::CNT_W-1:0]  w_q7;
    logic [ddw_pkg::CNT_W-1:0]  w_rem4;
    logic                       r_ok5 [NDATE];
    logic [1:0]                 r_kn5;
    logic [ddw_pkg::WD_W-1:0]   r_wd5 [NDATE];
    logic                       r_ord_err5;
    logic [ddw_pkg::CNT_W-1:0]  r_cnt5;
    logic [ddw_pkg::WEEK_W-1:0] r_q5;
    logic [ddw_pkg::WD_W-1:0]   r_rem5;

    assign w_q7   = (ddw_pkg::CNT_W'(r_q4) << 3) - ddw_pkg::CNT_W'(r_q4);
    assign w_rem4 = r_cnt4 - w_q7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en5) begin
            r_v5 <= r_v4;
        end
        if (w_en5) begin
            r_ok5      <= r_ok4;
            r_kn5      <= r_kn4;
            r_wd5      <= r_wd4;
            r_ord_err5 <= r_ord_err4;
            r_cnt5     <= r_cnt4;
            r_q5       <= r_q4;
            r_rem5     <= w_rem4[ddw_pkg::WD_W-1:0];
        end
    end

    assign o_out.valid          = r_v5;
    assign o_out.first_valid    = r_ok5[0];
    assign o_out.second_valid   = r_ok5[1];
    assign o_out.order_error    = r_ord_err5;
    assign o_out.day_count      = r_cnt5;
    assign o_out.whole_weeks    = r_q5;
    assign o_out.extra_days     = r_rem5;
    assign o_out.first_weekday  = r_wd5[0];
    assign o_out.second_weekday = r_wd5[1];
    assign o_out.weekday_known  = r_kn5;

    // ---------------- assertions ----------------
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_rem5 < 3'd7))
        else $error("extra_days out of range");

    a_week_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_cnt5 == (ddw_pkg::CNT_W'(r_q5) << 3) - ddw_pkg::CNT_W'(r_q5)
                            + ddw_pkg::CNT_W'(r_rem5)))
        else $error("weeks and days do not rebuild the day count");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && (r_ord_err5 || !r_ok5[0] || !r_ok5[1])) |-> (r_cnt5 == '0))
        else $error("nonzero day count on error");

    a_known_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> ((!r_kn5[0] || r_ok5[0]) && (!r_kn5[1] || r_ok5[1])))
        else $error("weekday known for an invalid date");

endmodule
